[hdl/f16fr_pkg.sv]
// ----------------------------------------------------------------------------
// f16fr_pkg
// shared types, codes and helpers of the fletcher-16 frame receiver
// ----------------------------------------------------------------------------
package f16fr_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 8;

  localparam logic [BYTE_W:0] FLETCHER_MOD = 9'h0ff;

  typedef enum logic [5:0] {
    PH_CODE     = 6'b000001,
    PH_LEN_HI   = 6'b000010,
    PH_LEN_LO   = 6'b000100,
    PH_PAYLOAD  = 6'b001000,
    PH_CHECK_HI = 6'b010000,
    PH_CHECK_LO = 6'b100000
  } phase_t;

  localparam logic [STATUS_W-1:0] ST_OK              = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOTE_CHECKSUM = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REQ_LARGE       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RESP_LARGE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNEXPECTED      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_CHECKSUM    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_FOLLOWS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_ERROR = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_LARGE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_LARGE = 8'd3;

  localparam logic [BYTE_W-1:0] RST_REPLY_FOLLOWS  = 8'd1;
  localparam logic [BYTE_W-1:0] RST_CHECKSUM_ERROR = 8'd2;
  localparam logic [BYTE_W-1:0] RST_REQUEST_LARGE  = 8'd3;
  localparam logic [BYTE_W-1:0] RST_RESPONSE_LARGE = 8'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] reply_follows_code;
    logic [BYTE_W-1:0] checksum_error_code;
    logic [BYTE_W-1:0] request_large_code;
    logic [BYTE_W-1:0] response_large_code;
  } codes_t;

  typedef struct packed {
    logic                valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic                is_payload;
    logic                frame_done;
    logic [STATUS_W-1:0] frame_status;
  } result_t;

  // both operands below 2*255, so one conditional subtract suffices
  function automatic logic [BYTE_W-1:0] add_mod255(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    logic [BYTE_W:0] r;
    s = {1'b0, a} + {1'b0, b};
    r = (s >= FLETCHER_MOD) ? (s - FLETCHER_MOD) : s;
    return r[BYTE_W-1:0];
  endfunction

endpackage

[hdl/f16fr_parser.sv]
// ----------------------------------------------------------------------------
// f16fr_parser
// frame state machine, length counter and fletcher-16 sums; one byte per step
// ----------------------------------------------------------------------------
module f16fr_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [f16fr_pkg::BYTE_W-1:0] rx_byte,
  input  f16fr_pkg::codes_t           codes,
  output f16fr_pkg::result_t          result
);

  f16fr_pkg::phase_t               phase_r, phase_nxt;
  logic [f16fr_pkg::LEN_W-1:0]     bytes_left_r, bytes_left_nxt;
  logic [f16fr_pkg::BYTE_W-1:0]    sum_lo_r, sum_lo_nxt;
  logic [f16fr_pkg::BYTE_W-1:0]    sum_hi_r, sum_hi_nxt;
  logic [f16fr_pkg::BYTE_W-1:0]    held_r, held_nxt;
  logic [f16fr_pkg::BYTE_W-1:0]    lo_add;

  assign lo_add = f16fr_pkg::add_mod255(sum_lo_r, rx_byte);

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    sum_lo_nxt     = sum_lo_r;
    sum_hi_nxt     = sum_hi_r;
    held_nxt       = held_r;
    result         = '0;
    unique case (phase_r)
      f16fr_pkg::PH_CODE: begin
        if (rx_byte == codes.checksum_error_code) begin
          result.valid        = 1'b1;
          result.frame_done   = 1'b1;
          result.frame_status = f16fr_pkg::ST_REMOTE_CHECKSUM;
        end else if (rx_byte == codes.request_large_code) begin
          result.valid        = 1'b1;
          result.frame_done   = 1'b1;
          result.frame_status = f16fr_pkg::ST_REQ_LARGE;
        end else if (rx_byte == codes.response_large_code) begin
          result.valid        = 1'b1;
          result.frame_done   = 1'b1;
          result.frame_status = f16fr_pkg::ST_RESP_LARGE;
        end else if (rx_byte != codes.reply_follows_code) begin
          result.valid        = 1'b1;
          result.frame_done   = 1'b1;
          result.frame_status = f16fr_pkg::ST_UNEXPECTED;
        end else begin
          sum_lo_nxt     = '0;
          sum_hi_nxt     = '0;
          bytes_left_nxt = '0;
          phase_nxt      = f16fr_pkg::PH_LEN_HI;
        end
      end
      f16fr_pkg::PH_LEN_HI: begin
        bytes_left_nxt = {rx_byte, {f16fr_pkg::BYTE_W{1'b0}}};
        phase_nxt      = f16fr_pkg::PH_LEN_LO;
      end
      f16fr_pkg::PH_LEN_LO: begin
        bytes_left_nxt = {bytes_left_r[f16fr_pkg::LEN_W-1:f16fr_pkg::BYTE_W], rx_byte};
        phase_nxt      = (bytes_left_nxt == '0) ? f16fr_pkg::PH_CHECK_HI
                                                : f16fr_pkg::PH_PAYLOAD;
      end
      f16fr_pkg::PH_PAYLOAD: begin
        sum_lo_nxt          = lo_add;
        sum_hi_nxt          = f16fr_pkg::add_mod255(sum_hi_r, lo_add);
        bytes_left_nxt      = bytes_left_r - 1'b1;
        if (bytes_left_nxt == '0) begin
          phase_nxt = f16fr_pkg::PH_CHECK_HI;
        end
        result.valid        = 1'b1;
        result.payload_byte = rx_byte;
        result.is_payload   = 1'b1;
      end
      f16fr_pkg::PH_CHECK_HI: begin
        held_nxt  = rx_byte;
        phase_nxt = f16fr_pkg::PH_CHECK_LO;
      end
      f16fr_pkg::PH_CHECK_LO: begin
        result.valid        = 1'b1;
        result.frame_done   = 1'b1;
        result.frame_status = ((held_r == sum_hi_r) && (rx_byte == sum_lo_r))
                              ? f16fr_pkg::ST_OK : f16fr_pkg::ST_BAD_CHECKSUM;
        phase_nxt           = f16fr_pkg::PH_CODE;
      end
      default: begin
        phase_nxt = f16fr_pkg::PH_CODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= f16fr_pkg::PH_CODE;
      bytes_left_r <= '0;
      sum_lo_r     <= '0;
      sum_hi_r     <= '0;
      held_r       <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      sum_lo_r     <= sum_lo_nxt;
      sum_hi_r     <= sum_hi_nxt;
      held_r       <= held_nxt;
    end
  end

endmodule

[hdl/fletcher16_frame_receiver_core.sv]
// ----------------------------------------------------------------------------
// fletcher16_frame_receiver_core
// length-prefixed frame receiver with fletcher-16 check
// ----------------------------------------------------------------------------
// Received bytes arrive on the in_ channel (valid/ready), one byte per
// transaction. Each frame is a code byte, a 16-bit big-endian length, the
// payload bytes and two check bytes (sum2, then sum1). Every payload byte
// gives one out_ transaction with out_is_payload set; the end of a frame
// gives one with out_frame_done and out_frame_status. Other bytes give none.
// The cfg_ channel writes the four code registers by index; it is always
// ready, and writes to unknown indexes are ignored.
// An accepted byte lands in an input register, is decoded once the output
// register can take its result, and the result then sits in the output register.
// One byte per cycle is sustained while out_ready is high, limited only
// by the single decode step between the two registers.
// When out_ready is low, the input register still takes one more byte;
// after that in_ready drops until the output register drains.
// Synchronous reset returns the decoder to waiting for a code byte, empties
// both registers and restores the default codes (1, 2, 3, 4).
// ----------------------------------------------------------------------------
module fletcher16_frame_receiver_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [f16fr_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [f16fr_pkg::BYTE_W-1:0]     out_payload_byte,
  output logic                             out_is_payload,
  output logic                             out_frame_done,
  output logic [f16fr_pkg::STATUS_W-1:0]   out_frame_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [f16fr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [f16fr_pkg::BYTE_W-1:0]     cfg_data
);

  f16fr_pkg::codes_t               codes_r;
  logic                            in_full_r;
  logic [f16fr_pkg::BYTE_W-1:0]    in_byte_r;
  f16fr_pkg::result_t              res;
  f16fr_pkg::result_t              out_r;
  logic                            advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_full_r && (!out_r.valid || out_ready);
  assign in_ready  = !in_full_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.reply_follows_code  <= f16fr_pkg::RST_REPLY_FOLLOWS;
      codes_r.checksum_error_code <= f16fr_pkg::RST_CHECKSUM_ERROR;
      codes_r.request_large_code  <= f16fr_pkg::RST_REQUEST_LARGE;
      codes_r.response_large_code <= f16fr_pkg::RST_RESPONSE_LARGE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        f16fr_pkg::CFG_REPLY_FOLLOWS:  codes_r.reply_follows_code  <= cfg_data;
        f16fr_pkg::CFG_CHECKSUM_ERROR: codes_r.checksum_error_code <= cfg_data;
        f16fr_pkg::CFG_REQUEST_LARGE:  codes_r.request_large_code  <= cfg_data;
        f16fr_pkg::CFG_RESPONSE_LARGE: codes_r.response_large_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full_r <= 1'b1;
    end else if (advance) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  f16fr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .codes   (codes_r),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (advance) begin
      out_r <= res;
    end else if (out_ready) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_valid        = out_r.valid;
  assign out_payload_byte = out_r.payload_byte;
  assign out_is_payload   = out_r.is_payload;
  assign out_frame_done   = out_r.frame_done;
  assign out_frame_status = out_r.frame_status;

endmodule

[hdl/f16fr_checker.sv]
// ----------------------------------------------------------------------------
// f16fr_checker
// port-level checks of the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
module f16fr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [f16fr_pkg::BYTE_W-1:0]     out_payload_byte,
  input logic                             out_is_payload,
  input logic                             out_frame_done,
  input logic [f16fr_pkg::STATUS_W-1:0]   out_frame_status
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_is_payload) && $stable(out_frame_done)
      && $stable(out_frame_status))
    else $error("stalled result changed");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_payload != out_frame_done))
    else $error("result is neither or both payload and status");

  a_clean_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_payload || out_payload_byte == '0)
      && (out_frame_done || out_frame_status == f16fr_pkg::ST_OK))
    else $error("unused result field not zero");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_frame_status <= f16fr_pkg::ST_BAD_CHECKSUM)
    else $error("status code out of range");

endmodule

bind fletcher16_frame_receiver_core f16fr_checker u_f16fr_checker (.*);
